// ===== hw/rtl/mar_pkg.sv =====
// shared types, constants and aes helper functions for the milenage response engine
// no dependencies

package mar_pkg;

    localparam int ROUNDS = 10;

    localparam logic [1:0] REG_KI_HIGH  = 2'd0;
    localparam logic [1:0] REG_KI_LOW   = 2'd1;
    localparam logic [1:0] REG_OPC_HIGH = 2'd2;
    localparam logic [1:0] REG_OPC_LOW  = 2'd3;

    localparam logic [127:0] C2_CONST = 128'h01;
    localparam logic [127:0] C3_CONST = 128'h02;
    localparam logic [127:0] C4_CONST = 128'h04;

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // request data that rides along the cell chains
    typedef struct packed {
        logic [47:0]  sqn_ak;
        logic [15:0]  amf;
        logic [63:0]  mac;
        logic [127:0] temp;
        logic [63:0]  res;
        logic [127:0] ck;
        logic [127:0] ik;
    } side_t;

    // byte k of a block, byte 0 most significant
    function automatic logic [7:0] get_byte(logic [127:0] b, int k);
        return b[127 - 8 * k -: 8];
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // sub bytes and shift rows, byte index is 4 * column + row
    function automatic logic [127:0] sub_shift(logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (4 * c + i) -: 8] = SBOX[get_byte(s, 4 * ((c + i) % 4) + i)];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4 * c);
            a1  = get_byte(s, 4 * c + 1);
            a2  = get_byte(s, 4 * c + 2);
            a3  = get_byte(s, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 8 * (4 * c) -: 8]     = a0 ^ all ^ xtime(a0 ^ a1);
            t[127 - 8 * (4 * c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[127 - 8 * (4 * c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[127 - 8 * (4 * c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // one step of the aes-128 key schedule
    function automatic logic [127:0] key_step(logic [127:0] k, logic [7:0] rc);
        logic [31:0] g;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        g  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ g;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== hw/rtl/milenage_auth_response_top.sv =====
// milenage f1..f5 and c3 response engine, top level
// depends on mar_pkg and mar_aes_chain

// Accepts one authentication transaction per clock while the output side does
// not stall and returns one result per transaction, in order, after three
// aes-128 encryptions in series (TEMP, then f2/f3/f4 side by side, then f1
// which needs AK from f2), each a row of ten round cells with on-the-fly key
// expansion, plus one output register. The user must write Ki and OPc through
// the config port only while no transaction is in flight; nothing enforces it.

module milenage_auth_response_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [63:0]  rand_high,
    input  logic [63:0]  rand_low,
    input  logic [47:0]  sqn_xor_ak,
    input  logic [15:0]  amf_field,
    input  logic [63:0]  mac_a,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         status,
    output logic [63:0]  res_value,
    output logic [63:0]  ck_high,
    output logic [63:0]  ck_low,
    output logic [63:0]  ik_high,
    output logic [63:0]  ik_low,
    output logic [63:0]  kc_value
);
    import mar_pkg::*;

    logic [63:0]  ki_high_reg;
    logic [63:0]  ki_low_reg;
    logic [63:0]  opc_high_reg;
    logic [63:0]  opc_low_reg;
    logic [127:0] key;
    logic [127:0] opc;
    logic         adv;

    logic         v1;
    logic [127:0] enc1;
    side_t        side0;
    side_t        side1;

    logic [127:0] x1;
    logic         v2;
    logic [127:0] enc2;
    logic [127:0] enc3;
    logic [127:0] enc4;
    side_t        side2;

    logic [127:0] o2;
    logic [47:0]  sqn;
    logic [127:0] in1x;
    logic [127:0] tmp2;
    side_t        side3;
    logic         v5;
    logic [127:0] enc5;
    side_t        side5;
    logic [127:0] o1;

    logic         out_valid_reg;
    logic         status_reg;
    logic [63:0]  res_reg;
    logic [127:0] ck_reg;
    logic [127:0] ik_reg;
    logic [63:0]  kc_reg;
    logic         match;

    assign key = {ki_high_reg, ki_low_reg};
    assign opc = {opc_high_reg, opc_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ki_high_reg  <= '0;
            ki_low_reg   <= '0;
            opc_high_reg <= '0;
            opc_low_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KI_HIGH:  ki_high_reg  <= cfg_data;
                REG_KI_LOW:   ki_low_reg   <= cfg_data;
                REG_OPC_HIGH: opc_high_reg <= cfg_data;
                REG_OPC_LOW:  opc_low_reg  <= cfg_data;
                default:      ki_high_reg  <= ki_high_reg;
            endcase
        end
    end

    // whole row of cells moves together unless the result register is held
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        side0        = '0;
        side0.sqn_ak = sqn_xor_ak;
        side0.amf    = amf_field;
        side0.mac    = mac_a;
    end

    mar_aes_chain u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (in_valid && in_ready),
        .block_in  ({rand_high, rand_low} ^ opc),
        .key       (key),
        .side_in   (side0),
        .valid_out (v1),
        .block_out (enc1),
        .side_out  (side1)
    );

    always_comb
    begin
        x1 = enc1 ^ opc;
    end

    side_t side1t;
    always_comb
    begin
        side1t      = side1;
        side1t.temp = enc1;
    end

    mar_aes_chain u_f2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (v1),
        .block_in  (x1 ^ C2_CONST),
        .key       (key),
        .side_in   (side1t),
        .valid_out (v2),
        .block_out (enc2),
        .side_out  (side2)
    );

    mar_aes_chain u_f3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (v1),
        .block_in  ({x1[95:0], x1[127:96]} ^ C3_CONST),
        .key       (key),
        .side_in   (side1t),
        .valid_out (),
        .block_out (enc3),
        .side_out  ()
    );

    mar_aes_chain u_f4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (v1),
        .block_in  ({x1[63:0], x1[127:64]} ^ C4_CONST),
        .key       (key),
        .side_in   (side1t),
        .valid_out (),
        .block_out (enc4),
        .side_out  ()
    );

    // ak from f5, sqn recovery and f1 input block
    always_comb
    begin
        o2        = enc2 ^ opc;
        sqn       = side2.sqn_ak ^ o2[127:80];
        in1x      = {sqn, side2.amf, sqn, side2.amf} ^ opc;
        tmp2      = {in1x[63:0], in1x[127:64]} ^ side2.temp;
        side3     = side2;
        side3.res = o2[63:0];
        side3.ck  = enc3 ^ opc;
        side3.ik  = enc4 ^ opc;
    end

    mar_aes_chain u_f1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (v2),
        .block_in  (tmp2),
        .key       (key),
        .side_in   (side3),
        .valid_out (v5),
        .block_out (enc5),
        .side_out  (side5)
    );

    assign o1    = enc5 ^ opc;
    assign match = (o1[127:64] == side5.mac);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v5;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v5)
        begin
            status_reg <= !match;
            res_reg    <= match ? side5.res : '0;
            ck_reg     <= match ? side5.ck : '0;
            ik_reg     <= match ? side5.ik : '0;
            kc_reg     <= match ? (side5.ck[127:64] ^ side5.ck[63:0]
                                   ^ side5.ik[127:64] ^ side5.ik[63:0]) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign res_value = res_reg;
    assign ck_high   = ck_reg[127:64];
    assign ck_low    = ck_reg[63:0];
    assign ik_high   = ik_reg[127:64];
    assign ik_low    = ik_reg[63:0];
    assign kc_value  = kc_reg;

endmodule

// ===== hw/rtl/mar_round_cell.sv =====
// one aes-128 round cell with its own key schedule step
// depends on mar_pkg

module mar_round_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 last,
    input  logic [7:0]           rcon,
    input  logic                 valid_in,
    input  logic [127:0]         state_in,
    input  logic [127:0]         key_in,
    input  mar_pkg::side_t       side_in,
    output logic                 valid_out,
    output logic [127:0]         state_out,
    output logic [127:0]         key_out,
    output mar_pkg::side_t       side_out
);
    import mar_pkg::*;

    logic         valid_reg;
    logic [127:0] state_reg;
    logic [127:0] key_reg;
    side_t        side_reg;
    logic [127:0] key_next;
    logic [127:0] state_next;
    logic [127:0] sub_sh;

    always_comb
    begin
        key_next   = key_step(key_in, rcon);
        sub_sh     = sub_shift(state_in);
        state_next = (last ? sub_sh : mix_columns(sub_sh)) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            side_reg  <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
    assign side_out  = side_reg;

endmodule

// ===== hw/rtl/mar_aes_chain.sv =====
// full aes-128 encryption as a row of ten round cells
// depends on mar_pkg and mar_round_cell

module mar_aes_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 valid_in,
    input  logic [127:0]         block_in,
    input  logic [127:0]         key,
    input  mar_pkg::side_t       side_in,
    output logic                 valid_out,
    output logic [127:0]         block_out,
    output mar_pkg::side_t       side_out
);
    import mar_pkg::*;

    logic         vld [ROUNDS + 1];
    logic [127:0] st  [ROUNDS + 1];
    logic [127:0] rk  [ROUNDS + 1];
    side_t        sd  [ROUNDS + 1];

    // initial round key addition
    assign vld[0] = valid_in;
    assign st[0]  = block_in ^ key;
    assign rk[0]  = key;
    assign sd[0]  = side_in;

    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_cell
        mar_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .last      (i == ROUNDS - 1),
            .rcon      (RCON[i]),
            .valid_in  (vld[i]),
            .state_in  (st[i]),
            .key_in    (rk[i]),
            .side_in   (sd[i]),
            .valid_out (vld[i + 1]),
            .state_out (st[i + 1]),
            .key_out   (rk[i + 1]),
            .side_out  (sd[i + 1])
        );
    end

    assign valid_out = vld[ROUNDS];
    assign block_out = st[ROUNDS];
    assign side_out  = sd[ROUNDS];

endmodule
